/* hdl/vt4_pkg.sv */
// Package for the 4x4 vertex transform: widths, register indexes, reset matrix
// and the stage-enable struct shared by the top level and the dot-product lane.
// Depends on nothing.
package vt4_pkg;

   localparam int NumComp       = 4;
   localparam int CompWidth     = 32;
   localparam int CoeffWidth    = 16;
   localparam int CsrIndexWidth = 8;
   localparam int CsrDataWidth  = NumComp * CoeffWidth;
   localparam int ProdWidth     = CompWidth + CoeffWidth;
   localparam int PairWidth     = ProdWidth + 1;
   localparam int SumWidth      = ProdWidth + 2;
   localparam int FracShift     = 12;

   // register indexes
   localparam logic [CsrIndexWidth-1:0] CsrColX = 8'd0;
   localparam logic [CsrIndexWidth-1:0] CsrColY = 8'd1;
   localparam logic [CsrIndexWidth-1:0] CsrColZ = 8'd2;
   localparam logic [CsrIndexWidth-1:0] CsrColW = 8'd3;

   // identity matrix in Q4.12
   localparam logic [CsrDataWidth-1:0] ResetColX = 64'h0000_0000_0000_1000;
   localparam logic [CsrDataWidth-1:0] ResetColY = 64'h0000_0000_1000_0000;
   localparam logic [CsrDataWidth-1:0] ResetColZ = 64'h0000_1000_0000_0000;
   localparam logic [CsrDataWidth-1:0] ResetColW = 64'h1000_0000_0000_0000;

   typedef logic signed [CompWidth-1:0] comp_type;

   typedef struct packed {
      logic s2_load;
      logic s3_load;
      logic s4_load;
   } stage_en_type;

endpackage

/* hdl/vt4_dot_lane.sv */
// One output component: four products, two pair sums, final sum with floor
// shift and saturation, registered in three stages. Uses vt4_pkg.
module vt4_dot_lane (
   input  logic                                clock,
   input  vt4_pkg::stage_en_type               stage_en,
   input  vt4_pkg::comp_type                   comp [vt4_pkg::NumComp],
   input  logic [vt4_pkg::CsrDataWidth-1:0]    coeffs,
   output vt4_pkg::comp_type                   result,
   output logic                                sat
);
   import vt4_pkg::*;

   localparam int ShiftedWidth = SumWidth - FracShift;

   logic signed [CoeffWidth-1:0]   coeff [NumComp];
   logic signed [ProdWidth-1:0]    prod_in [NumComp];
   logic signed [ProdWidth-1:0]    prod_ff [NumComp];
   logic signed [PairWidth-1:0]    pair_in [2];
   logic signed [PairWidth-1:0]    pair_ff [2];
   logic signed [SumWidth-1:0]     total;
   logic signed [ShiftedWidth-1:0] shifted;
   logic                           over;
   comp_type                       result_in;
   comp_type                       result_ff;
   logic                           sat_in;
   logic                           sat_ff;

   // stage 2: one multiply per component
   always_comb begin
      for (int k = 0; k < NumComp; k++) begin
         coeff[k]   = signed'(coeffs[k*CoeffWidth +: CoeffWidth]);
         prod_in[k] = ProdWidth'(comp[k]) * ProdWidth'(coeff[k]);
      end
   end

   always_ff @(posedge clock) begin
      if (stage_en.s2_load) begin
         prod_ff <= prod_in;
      end
   end

   // stage 3: pair sums
   assign pair_in[0] = PairWidth'(prod_ff[0]) + PairWidth'(prod_ff[1]);
   assign pair_in[1] = PairWidth'(prod_ff[2]) + PairWidth'(prod_ff[3]);

   always_ff @(posedge clock) begin
      if (stage_en.s3_load) begin
         pair_ff <= pair_in;
      end
   end

   // stage 4: final sum, floor shift by dropping low bits, then clip
   assign total   = SumWidth'(pair_ff[0]) + SumWidth'(pair_ff[1]);
   assign shifted = total[SumWidth-1:FracShift];
   assign over    = (shifted[ShiftedWidth-1:CompWidth-1] != '0) &&
                    (shifted[ShiftedWidth-1:CompWidth-1] != '1);

   always_comb begin
      sat_in = over;
      if (!over) begin
         result_in = shifted[CompWidth-1:0];
      end else if (shifted[ShiftedWidth-1]) begin
         result_in = {1'b1, {(CompWidth-1){1'b0}}};
      end else begin
         result_in = {1'b0, {(CompWidth-1){1'b1}}};
      end
   end

   always_ff @(posedge clock) begin
      if (stage_en.s4_load) begin
         result_ff <= result_in;
         sat_ff    <= sat_in;
      end
   end

   assign result = result_ff;
   assign sat    = sat_ff;

endmodule

/* hdl/vertex_transform_4x4_unit.sv */
// The input register loads at the accepting edge; the word then passes the
// multiply, pair-add and final add/clip stages and raises rsp_valid.
// Throughput: one vertex per cycle; the four-stage multiply/add pipeline
// moves on whenever the output register is empty or being taken.
// Reset (synchronous): clears every stage valid and loads the identity matrix.
// Uses vt4_pkg and vt4_dot_lane.
module vertex_transform_4x4_unit (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic signed [vt4_pkg::CompWidth-1:0] req_in_x,
   input  logic signed [vt4_pkg::CompWidth-1:0] req_in_y,
   input  logic signed [vt4_pkg::CompWidth-1:0] req_in_z,
   input  logic signed [vt4_pkg::CompWidth-1:0] req_in_w,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic signed [vt4_pkg::CompWidth-1:0] rsp_out_x,
   output logic signed [vt4_pkg::CompWidth-1:0] rsp_out_y,
   output logic signed [vt4_pkg::CompWidth-1:0] rsp_out_z,
   output logic signed [vt4_pkg::CompWidth-1:0] rsp_out_w,
   output logic                                 rsp_saturated,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [vt4_pkg::CsrIndexWidth-1:0]    csr_index,
   input  logic [vt4_pkg::CsrDataWidth-1:0]     csr_data
);
   import vt4_pkg::*;

   logic [CsrDataWidth-1:0] coeff_ff [NumComp];
   logic [CsrDataWidth-1:0] coeff_in [NumComp];
   comp_type                comp_ff [NumComp];
   comp_type                result [NumComp];
   logic [NumComp-1:0]      lane_sat;
   logic                    v1_ff, v2_ff, v3_ff, v4_ff;
   logic                    s1_load;
   stage_en_type            stage_en;

   // stage enables: a stage loads when empty or when its word moves on
   assign stage_en.s4_load = !v4_ff || rsp_ready;
   assign stage_en.s3_load = !v3_ff || stage_en.s4_load;
   assign stage_en.s2_load = !v2_ff || stage_en.s3_load;
   assign s1_load          = !v1_ff || stage_en.s2_load;
   assign req_ready        = s1_load;

   // advance the valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else begin
         if (s1_load)          v1_ff <= req_valid;
         if (stage_en.s2_load) v2_ff <= v1_ff;
         if (stage_en.s3_load) v3_ff <= v2_ff;
         if (stage_en.s4_load) v4_ff <= v3_ff;
      end
   end

   // stage 1: hold the incoming vertex
   always_ff @(posedge clock) begin
      if (s1_load) begin
         comp_ff[0] <= req_in_x;
         comp_ff[1] <= req_in_y;
         comp_ff[2] <= req_in_z;
         comp_ff[3] <= req_in_w;
      end
   end

   // coefficient registers; out-of-range indexes drop the write
   assign csr_ready = 1'b1;

   always_comb begin
      coeff_in = coeff_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CsrColX: coeff_in[0] = csr_data;
            CsrColY: coeff_in[1] = csr_data;
            CsrColZ: coeff_in[2] = csr_data;
            CsrColW: coeff_in[3] = csr_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         coeff_ff[0] <= ResetColX;
         coeff_ff[1] <= ResetColY;
         coeff_ff[2] <= ResetColZ;
         coeff_ff[3] <= ResetColW;
      end else begin
         coeff_ff <= coeff_in;
      end
   end

   // one dot-product lane per output component
   for (genvar r = 0; r < NumComp; r++) begin : g_lane
      vt4_dot_lane u_lane (
         .clock    (clock),
         .stage_en (stage_en),
         .comp     (comp_ff),
         .coeffs   (coeff_ff[r]),
         .result   (result[r]),
         .sat      (lane_sat[r])
      );
   end

   assign rsp_valid     = v4_ff;
   assign rsp_out_x     = result[0];
   assign rsp_out_y     = result[1];
   assign rsp_out_z     = result[2];
   assign rsp_out_w     = result[3];
   assign rsp_saturated = |lane_sat;

`ifndef NO_ASSERTIONS
   // an accepted word lands in stage 1
   a_accept_lands: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> v1_ff)
      else $error("accepted word missing from stage 1");

   // an empty output register means the pipe can take a word
   a_empty_ready: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("ready low with empty output register");

   // a stalled stage 3 word is kept while the output holds
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      v3_ff && v4_ff && !rsp_ready |=> v3_ff && v4_ff)
      else $error("stalled word lost in stage 3 or 4");

   // a write to the x column takes effect
   a_csr_write: assert property (@(posedge clock) disable iff (reset)
      csr_valid && csr_ready && (csr_index == CsrColX) |=>
      coeff_ff[0] == $past(csr_data))
      else $error("x column write not applied");
`endif

endmodule
